@@ hdl/strided_image_copy_address_gen_assert.svh @@
// assertion macros of the address generator, included by the walker module
`ifndef STRIDED_IMAGE_COPY_ADDRESS_GEN_ASSERT_SVH
`define STRIDED_IMAGE_COPY_ADDRESS_GEN_ASSERT_SVH

// same-cycle implication
`define SIC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sic assertion failed");

// next-cycle implication
`define SIC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sic assertion failed");

`endif

@@ hdl/sic_pkg.sv @@
// shared constants, types and register codes of the strided copy address generator
package sic_pkg;

   localparam int ADDR_WIDTH        = 32;
   localparam int DIM_WIDTH         = 14;
   localparam int MAX_ADDR_WIDTH    = 64;
   localparam int OUT_WIDTH         = 32;

   localparam int CSR_DATA_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH    = 5;
   localparam int REG_INDEX_LSB     = 2;

   localparam int MODE_WIDTH        = 4;
   localparam int BPP_WIDTH         = 8;
   localparam int BPB_WIDTH         = 12;
   localparam int BASE_WIDTH        = 32;
   localparam int ROW_PITCH_WIDTH   = 24;
   localparam int SLICE_PITCH_WIDTH = 32;

   localparam int MODE_BLOCK        = 0;
   localparam int MODE_ADJ_SRC      = 1;
   localparam int MODE_ADJ_DST      = 2;
   localparam int MODE_3D           = 3;

   localparam logic [BPP_WIDTH-1:0] BPP_RESET = 8'd32;

   localparam int BLOCK_SHIFT       = 2;
   localparam int BLOCK_ROUND       = 3;
   localparam int BYTE_SHIFT        = 3;
   localparam int BPB_SHIFT         = 4;
   localparam int BLOCK_X_SHIFT     = 1;

   typedef enum logic [2:0] {
      REG_MODE_FLAGS      = 3'd0,
      REG_BITS_PER_PIXEL  = 3'd1,
      REG_SRC_BASE        = 3'd2,
      REG_DST_BASE        = 3'd3,
      REG_SRC_ROW_PITCH   = 3'd4,
      REG_DST_ROW_PITCH   = 3'd5,
      REG_SRC_SLICE_PITCH = 3'd6,
      REG_DST_SLICE_PITCH = 3'd7
   } sic_reg_type;

   typedef enum logic [1:0] {
      BURST_SLICE   = 2'd0,
      BURST_ROW     = 2'd1,
      BURST_PER_ROW = 2'd2
   } sic_burst_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]        mode_flags;
      logic [BPP_WIDTH-1:0]         bits_per_pixel;
      logic [BASE_WIDTH-1:0]        src_base;
      logic [BASE_WIDTH-1:0]        dst_base;
      logic [ROW_PITCH_WIDTH-1:0]   src_row_pitch;
      logic [ROW_PITCH_WIDTH-1:0]   dst_row_pitch;
      logic [SLICE_PITCH_WIDTH-1:0] src_slice_pitch;
      logic [SLICE_PITCH_WIDTH-1:0] dst_slice_pitch;
   } sic_cfg_type;

   typedef struct packed {
      logic          valid;
      logic          start;
      logic          empty;
      sic_burst_type burst_mode;
   } sic_cmd_type;

endpackage

@@ hdl/sic_channel_if.sv @@
// request and response channel interfaces
interface sic_req_if #(
   parameter int DIM_WIDTH = sic_pkg::DIM_WIDTH
) ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [DIM_WIDTH-1:0] offset_x;
   logic [DIM_WIDTH-1:0] offset_y;
   logic [DIM_WIDTH-1:0] offset_z;
   logic [DIM_WIDTH-1:0] copy_w;
   logic [DIM_WIDTH-1:0] copy_h;
   logic [DIM_WIDTH-1:0] copy_d;
   logic [DIM_WIDTH-1:0] total_w;
   logic [DIM_WIDTH-1:0] total_h;

   modport source (
      output valid, kind, offset_x, offset_y, offset_z, copy_w, copy_h, copy_d,
             total_w, total_h,
      input  ready
   );
   modport sink (
      input  valid, kind, offset_x, offset_y, offset_z, copy_w, copy_h, copy_d,
             total_w, total_h,
      output ready
   );
endinterface

interface sic_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic [sic_pkg::OUT_WIDTH-1:0] src_addr;
   logic [sic_pkg::OUT_WIDTH-1:0] dst_addr;
   logic [sic_pkg::OUT_WIDTH-1:0] byte_count;
   logic                          last;

   modport source (
      output valid, src_addr, dst_addr, byte_count, last,
      input  ready
   );
   modport sink (
      input  valid, src_addr, dst_addr, byte_count, last,
      output ready
   );
endinterface

@@ hdl/sic_csr.sv @@
// apb configuration registers
module sic_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sic_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [sic_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [sic_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output sic_pkg::sic_cfg_type                cfg
);

   sic_pkg::sic_cfg_type cfg_ff;
   sic_pkg::sic_cfg_type cfg_in;
   sic_pkg::sic_cfg_type cfg_reset;
   sic_pkg::sic_reg_type reg_sel;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_sel = sic_pkg::sic_reg_type'(paddr[sic_pkg::CSR_ADDR_WIDTH-1:sic_pkg::REG_INDEX_LSB]);
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_reset                = '0;
      cfg_reset.bits_per_pixel = sic_pkg::BPP_RESET;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            sic_pkg::REG_MODE_FLAGS:      cfg_in.mode_flags      = pwdata[sic_pkg::MODE_WIDTH-1:0];
            sic_pkg::REG_BITS_PER_PIXEL:  cfg_in.bits_per_pixel  = pwdata[sic_pkg::BPP_WIDTH-1:0];
            sic_pkg::REG_SRC_BASE:        cfg_in.src_base        = pwdata[sic_pkg::BASE_WIDTH-1:0];
            sic_pkg::REG_DST_BASE:        cfg_in.dst_base        = pwdata[sic_pkg::BASE_WIDTH-1:0];
            sic_pkg::REG_SRC_ROW_PITCH:   cfg_in.src_row_pitch   =
               pwdata[sic_pkg::ROW_PITCH_WIDTH-1:0];
            sic_pkg::REG_DST_ROW_PITCH:   cfg_in.dst_row_pitch   =
               pwdata[sic_pkg::ROW_PITCH_WIDTH-1:0];
            sic_pkg::REG_SRC_SLICE_PITCH: cfg_in.src_slice_pitch =
               pwdata[sic_pkg::SLICE_PITCH_WIDTH-1:0];
            sic_pkg::REG_DST_SLICE_PITCH: cfg_in.dst_slice_pitch =
               pwdata[sic_pkg::SLICE_PITCH_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         sic_pkg::REG_MODE_FLAGS:      prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.mode_flags);
         sic_pkg::REG_BITS_PER_PIXEL:  prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.bits_per_pixel);
         sic_pkg::REG_SRC_BASE:        prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.src_base);
         sic_pkg::REG_DST_BASE:        prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.dst_base);
         sic_pkg::REG_SRC_ROW_PITCH:   prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.src_row_pitch);
         sic_pkg::REG_DST_ROW_PITCH:   prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.dst_row_pitch);
         sic_pkg::REG_SRC_SLICE_PITCH: prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.src_slice_pitch);
         sic_pkg::REG_DST_SLICE_PITCH: prdata = sic_pkg::CSR_DATA_WIDTH'(cfg_ff.dst_slice_pitch);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_reset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/sic_setup.sv @@
// request stages: block conversion and products, then start address sums
module sic_setup #(
   parameter int ADDR_WIDTH = sic_pkg::ADDR_WIDTH,
   parameter int DIM_WIDTH  = sic_pkg::DIM_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sic_pkg::sic_cfg_type   cfg,
   sic_req_if.sink                req,
   input  logic                   advance,
   output sic_pkg::sic_cmd_type   cmd,
   output logic [DIM_WIDTH-1:0]   cmd_rows_total,
   output logic [DIM_WIDTH-1:0]   cmd_slices_total,
   output logic [ADDR_WIDTH-1:0]  cmd_bytes,
   output logic [ADDR_WIDTH-1:0]  cmd_src,
   output logic [ADDR_WIDTH-1:0]  cmd_dst
);

   localparam int ZW = DIM_WIDTH + sic_pkg::SLICE_PITCH_WIDTH;
   localparam int YW = DIM_WIDTH + sic_pkg::ROW_PITCH_WIDTH;
   localparam int XW = DIM_WIDTH + sic_pkg::BPP_WIDTH + sic_pkg::BLOCK_X_SHIFT;
   localparam int PW = DIM_WIDTH + sic_pkg::BPB_WIDTH;

   function automatic logic [DIM_WIDTH-1:0] to_blocks(input logic [DIM_WIDTH-1:0] v);
      logic [DIM_WIDTH:0] r;
      r = (DIM_WIDTH+1)'(v) + (DIM_WIDTH+1)'(sic_pkg::BLOCK_ROUND);
      return DIM_WIDTH'(r >> sic_pkg::BLOCK_SHIFT);
   endfunction

   // stage one
   logic                   s1_v_ff, s1_v_in;
   logic                   s1_start_ff, s1_start_in;
   logic                   s1_empty_ff, s1_empty_in;
   sic_pkg::sic_burst_type s1_mode_ff, s1_mode_in;
   logic [DIM_WIDTH-1:0]   s1_rows_ff, s1_rows_in;
   logic [DIM_WIDTH-1:0]   s1_slices_ff, s1_slices_in;
   logic [ADDR_WIDTH-1:0]  s1_bytes_ff, s1_bytes_in;
   logic [ADDR_WIDTH-1:0]  s1_zs_ff, s1_zs_in;
   logic [ADDR_WIDTH-1:0]  s1_zd_ff, s1_zd_in;
   logic [ADDR_WIDTH-1:0]  s1_ys_ff, s1_ys_in;
   logic [ADDR_WIDTH-1:0]  s1_yd_ff, s1_yd_in;
   logic [ADDR_WIDTH-1:0]  s1_x_ff, s1_x_in;

   // stage two
   logic                   s2_v_ff, s2_v_in;
   logic                   s2_start_ff, s2_start_in;
   logic                   s2_empty_ff, s2_empty_in;
   sic_pkg::sic_burst_type s2_mode_ff, s2_mode_in;
   logic [DIM_WIDTH-1:0]   s2_rows_ff, s2_rows_in;
   logic [DIM_WIDTH-1:0]   s2_slices_ff, s2_slices_in;
   logic [ADDR_WIDTH-1:0]  s2_bytes_ff, s2_bytes_in;
   logic [ADDR_WIDTH-1:0]  s2_src_ff, s2_src_in;
   logic [ADDR_WIDTH-1:0]  s2_dst_ff, s2_dst_in;

   logic                   s1_take, s2_take, s1_load, s2_load;
   logic                   blk;
   logic [DIM_WIDTH-1:0]   copy_bw, copy_bh, tot_bw, tot_bh, off_x_sel, off_y;
   logic [sic_pkg::BPB_WIDTH-1:0] bpb;
   logic [XW-1:0]          x_prod, x_bytes;
   logic [ZW-1:0]          zs_prod, zd_prod, slice_bytes;
   logic [YW-1:0]          ys_prod, yd_prod, row_bytes;
   logic [PW-1:0]          pix_prod;
   logic                   whole_row, whole_slice;
   logic [DIM_WIDTH-1:0]   rows_sel;
   logic [ADDR_WIDTH-1:0]  adj_src, adj_dst;

   assign s2_take   = !s2_v_ff || advance;
   assign s1_take   = !s1_v_ff || s2_take;
   assign req.ready = s1_take;
   assign s1_load   = s1_take && req.valid;
   assign s2_load   = s2_take && s1_v_ff;

   // block conversion and products
   always_comb begin
      blk       = cfg.mode_flags[sic_pkg::MODE_BLOCK];
      copy_bw   = blk ? to_blocks(req.copy_w)  : req.copy_w;
      copy_bh   = blk ? to_blocks(req.copy_h)  : req.copy_h;
      tot_bw    = blk ? to_blocks(req.total_w) : req.total_w;
      tot_bh    = blk ? to_blocks(req.total_h) : req.total_h;
      off_x_sel = blk ? (req.offset_x >> sic_pkg::BLOCK_SHIFT) : req.offset_x;
      off_y     = blk ? (req.offset_y >> sic_pkg::BLOCK_SHIFT) : req.offset_y;
      bpb       = blk ? (sic_pkg::BPB_WIDTH'(cfg.bits_per_pixel) << sic_pkg::BPB_SHIFT)
                      : sic_pkg::BPB_WIDTH'(cfg.bits_per_pixel);

      x_prod  = XW'(off_x_sel) * XW'(cfg.bits_per_pixel);
      x_bytes = blk ? (x_prod << sic_pkg::BLOCK_X_SHIFT) : (x_prod >> sic_pkg::BYTE_SHIFT);
      zs_prod = ZW'(req.offset_z) * ZW'(cfg.src_slice_pitch);
      zd_prod = ZW'(req.offset_z) * ZW'(cfg.dst_slice_pitch);
      ys_prod = YW'(off_y) * YW'(cfg.src_row_pitch);
      yd_prod = YW'(off_y) * YW'(cfg.dst_row_pitch);

      slice_bytes = ZW'(cfg.src_slice_pitch) * ZW'(req.copy_d);
      row_bytes   = YW'(cfg.src_row_pitch) * YW'(copy_bh);
      pix_prod    = (PW'(bpb) * PW'(copy_bw)) >> sic_pkg::BYTE_SHIFT;

      whole_row   = (copy_bw == tot_bw) && (cfg.src_row_pitch == cfg.dst_row_pitch);
      whole_slice = whole_row && cfg.mode_flags[sic_pkg::MODE_3D] && (copy_bh == tot_bh) &&
                    (cfg.src_slice_pitch == cfg.dst_slice_pitch);
   end

   always_comb begin
      s1_v_in      = s1_take ? req.valid : s1_v_ff;
      s1_start_in  = s1_start_ff;
      s1_empty_in  = s1_empty_ff;
      s1_mode_in   = s1_mode_ff;
      s1_rows_in   = s1_rows_ff;
      s1_slices_in = s1_slices_ff;
      s1_bytes_in  = s1_bytes_ff;
      s1_zs_in     = s1_zs_ff;
      s1_zd_in     = s1_zd_ff;
      s1_ys_in     = s1_ys_ff;
      s1_yd_in     = s1_yd_ff;
      s1_x_in      = s1_x_ff;
      rows_sel     = copy_bh;
      if (s1_load) begin
         s1_start_in = !req.kind;
         if (whole_slice) begin
            s1_mode_in   = sic_pkg::BURST_SLICE;
            rows_sel     = DIM_WIDTH'(1);
            s1_slices_in = DIM_WIDTH'(1);
            s1_bytes_in  = ADDR_WIDTH'(slice_bytes);
         end else if (whole_row) begin
            s1_mode_in   = sic_pkg::BURST_ROW;
            rows_sel     = DIM_WIDTH'(1);
            s1_slices_in = req.copy_d;
            s1_bytes_in  = ADDR_WIDTH'(row_bytes);
         end else begin
            s1_mode_in   = sic_pkg::BURST_PER_ROW;
            rows_sel     = copy_bh;
            s1_slices_in = req.copy_d;
            s1_bytes_in  = ADDR_WIDTH'(pix_prod);
         end
         s1_rows_in  = rows_sel;
         s1_empty_in = (req.copy_d == '0) || (rows_sel == '0);
         s1_zs_in    = ADDR_WIDTH'(zs_prod);
         s1_zd_in    = ADDR_WIDTH'(zd_prod);
         s1_ys_in    = ADDR_WIDTH'(ys_prod);
         s1_yd_in    = ADDR_WIDTH'(yd_prod);
         s1_x_in     = ADDR_WIDTH'(x_bytes);
      end
   end

   // start address sums
   always_comb begin
      adj_src = s1_zs_ff + s1_ys_ff + s1_x_ff;
      adj_dst = s1_zd_ff + s1_yd_ff + s1_x_ff;

      s2_v_in      = s2_take ? s1_v_ff : s2_v_ff;
      s2_start_in  = s2_start_ff;
      s2_empty_in  = s2_empty_ff;
      s2_mode_in   = s2_mode_ff;
      s2_rows_in   = s2_rows_ff;
      s2_slices_in = s2_slices_ff;
      s2_bytes_in  = s2_bytes_ff;
      s2_src_in    = s2_src_ff;
      s2_dst_in    = s2_dst_ff;
      if (s2_load) begin
         s2_start_in  = s1_start_ff;
         s2_empty_in  = s1_empty_ff;
         s2_mode_in   = s1_mode_ff;
         s2_rows_in   = s1_rows_ff;
         s2_slices_in = s1_slices_ff;
         s2_bytes_in  = s1_bytes_ff;
         s2_src_in    = ADDR_WIDTH'(cfg.src_base) +
                        (cfg.mode_flags[sic_pkg::MODE_ADJ_SRC] ? adj_src : '0);
         s2_dst_in    = ADDR_WIDTH'(cfg.dst_base) +
                        (cfg.mode_flags[sic_pkg::MODE_ADJ_DST] ? adj_dst : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_start_ff  <= s1_start_in;
      s1_empty_ff  <= s1_empty_in;
      s1_mode_ff   <= s1_mode_in;
      s1_rows_ff   <= s1_rows_in;
      s1_slices_ff <= s1_slices_in;
      s1_bytes_ff  <= s1_bytes_in;
      s1_zs_ff     <= s1_zs_in;
      s1_zd_ff     <= s1_zd_in;
      s1_ys_ff     <= s1_ys_in;
      s1_yd_ff     <= s1_yd_in;
      s1_x_ff      <= s1_x_in;
      s2_start_ff  <= s2_start_in;
      s2_empty_ff  <= s2_empty_in;
      s2_mode_ff   <= s2_mode_in;
      s2_rows_ff   <= s2_rows_in;
      s2_slices_ff <= s2_slices_in;
      s2_bytes_ff  <= s2_bytes_in;
      s2_src_ff    <= s2_src_in;
      s2_dst_ff    <= s2_dst_in;
   end

   assign cmd.valid        = s2_v_ff;
   assign cmd.start        = s2_start_ff;
   assign cmd.empty        = s2_empty_ff;
   assign cmd.burst_mode   = s2_mode_ff;
   assign cmd_rows_total   = s2_rows_ff;
   assign cmd_slices_total = s2_slices_ff;
   assign cmd_bytes        = s2_bytes_ff;
   assign cmd_src          = s2_src_ff;
   assign cmd_dst          = s2_dst_ff;

endmodule

@@ hdl/sic_walker.sv @@
// row and slice walker with the response register
`include "strided_image_copy_address_gen_assert.svh"

module sic_walker #(
   parameter int ADDR_WIDTH = sic_pkg::ADDR_WIDTH,
   parameter int DIM_WIDTH  = sic_pkg::DIM_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sic_pkg::sic_cfg_type   cfg,
   input  sic_pkg::sic_cmd_type   cmd,
   input  logic [DIM_WIDTH-1:0]   cmd_rows_total,
   input  logic [DIM_WIDTH-1:0]   cmd_slices_total,
   input  logic [ADDR_WIDTH-1:0]  cmd_bytes,
   input  logic [ADDR_WIDTH-1:0]  cmd_src,
   input  logic [ADDR_WIDTH-1:0]  cmd_dst,
   output logic                   advance,
   sic_rsp_if.source              rsp
);

   logic                   active_ff, active_in;
   sic_pkg::sic_burst_type burst_mode_ff, burst_mode_in;
   logic [DIM_WIDTH-1:0]   row_count_ff, row_count_in;
   logic [DIM_WIDTH-1:0]   slice_count_ff, slice_count_in;
   logic [DIM_WIDTH-1:0]   rows_total_ff, rows_total_in;
   logic [DIM_WIDTH-1:0]   slices_total_ff, slices_total_in;
   logic [ADDR_WIDTH-1:0]  burst_bytes_ff, burst_bytes_in;
   logic [ADDR_WIDTH-1:0]  src_slice_addr_ff, src_slice_addr_in;
   logic [ADDR_WIDTH-1:0]  dst_slice_addr_ff, dst_slice_addr_in;
   logic [ADDR_WIDTH-1:0]  src_row_addr_ff, src_row_addr_in;
   logic [ADDR_WIDTH-1:0]  dst_row_addr_ff, dst_row_addr_in;

   logic                          out_v_ff, out_v_in;
   logic [sic_pkg::OUT_WIDTH-1:0] out_src_ff, out_src_in;
   logic [sic_pkg::OUT_WIDTH-1:0] out_dst_ff, out_dst_in;
   logic [sic_pkg::OUT_WIDTH-1:0] out_bytes_ff, out_bytes_in;
   logic                          out_last_ff, out_last_in;

   logic                   fire, emit, fin, row_wrap;
   sic_pkg::sic_burst_type cur_mode;
   logic [DIM_WIDTH-1:0]   cur_row, cur_slice, cur_rows, cur_slices;
   logic [DIM_WIDTH:0]     row_inc, slice_inc;
   logic [ADDR_WIDTH-1:0]  cur_bytes, cur_src_slice, cur_dst_slice, cur_src_row, cur_dst_row;
   logic [ADDR_WIDTH-1:0]  src_slice_step, dst_slice_step, src_row_step, dst_row_step;
   logic [sic_pkg::MAX_ADDR_WIDTH-1:0] src_wide, dst_wide, bytes_wide;

   assign advance = !out_v_ff || rsp.ready;
   assign fire    = cmd.valid && advance;

   always_comb begin
      cur_mode      = cmd.start ? cmd.burst_mode  : burst_mode_ff;
      cur_row       = cmd.start ? '0               : row_count_ff;
      cur_slice     = cmd.start ? '0               : slice_count_ff;
      cur_rows      = cmd.start ? cmd_rows_total   : rows_total_ff;
      cur_slices    = cmd.start ? cmd_slices_total : slices_total_ff;
      cur_bytes     = cmd.start ? cmd_bytes        : burst_bytes_ff;
      cur_src_slice = cmd.start ? cmd_src          : src_slice_addr_ff;
      cur_dst_slice = cmd.start ? cmd_dst          : dst_slice_addr_ff;
      cur_src_row   = cmd.start ? cmd_src          : src_row_addr_ff;
      cur_dst_row   = cmd.start ? cmd_dst          : dst_row_addr_ff;

      emit      = fire && (cmd.start ? !cmd.empty : active_ff);
      row_inc   = (DIM_WIDTH+1)'(cur_row) + (DIM_WIDTH+1)'(1);
      slice_inc = (DIM_WIDTH+1)'(cur_slice) + (DIM_WIDTH+1)'(1);
      row_wrap  = row_inc >= (DIM_WIDTH+1)'(cur_rows);
      fin       = row_wrap && (slice_inc >= (DIM_WIDTH+1)'(cur_slices));

      src_slice_step = cur_src_slice + ADDR_WIDTH'(cfg.src_slice_pitch);
      dst_slice_step = cur_dst_slice + ADDR_WIDTH'(cfg.dst_slice_pitch);
      src_row_step   = cur_src_row + ADDR_WIDTH'(cfg.src_row_pitch);
      dst_row_step   = cur_dst_row + ADDR_WIDTH'(cfg.dst_row_pitch);

      src_wide   = sic_pkg::MAX_ADDR_WIDTH'(cur_src_row);
      dst_wide   = sic_pkg::MAX_ADDR_WIDTH'(cur_dst_row);
      bytes_wide = sic_pkg::MAX_ADDR_WIDTH'(cur_bytes);
   end

   always_comb begin
      active_in         = active_ff;
      burst_mode_in     = burst_mode_ff;
      row_count_in      = row_count_ff;
      slice_count_in    = slice_count_ff;
      rows_total_in     = rows_total_ff;
      slices_total_in   = slices_total_ff;
      burst_bytes_in    = burst_bytes_ff;
      src_slice_addr_in = src_slice_addr_ff;
      dst_slice_addr_in = dst_slice_addr_ff;
      src_row_addr_in   = src_row_addr_ff;
      dst_row_addr_in   = dst_row_addr_ff;
      if (fire) begin
         active_in         = cmd.start ? !cmd.empty : active_ff;
         burst_mode_in     = cur_mode;
         row_count_in      = cur_row;
         slice_count_in    = cur_slice;
         rows_total_in     = cur_rows;
         slices_total_in   = cur_slices;
         burst_bytes_in    = cur_bytes;
         src_slice_addr_in = cur_src_slice;
         dst_slice_addr_in = cur_dst_slice;
         src_row_addr_in   = cur_src_row;
         dst_row_addr_in   = cur_dst_row;
         if (emit) begin
            if (fin) begin
               active_in = 1'b0;
            end else if (row_wrap) begin
               row_count_in      = '0;
               slice_count_in    = DIM_WIDTH'(slice_inc);
               src_slice_addr_in = src_slice_step;
               dst_slice_addr_in = dst_slice_step;
               src_row_addr_in   = src_slice_step;
               dst_row_addr_in   = dst_slice_step;
            end else begin
               row_count_in    = DIM_WIDTH'(row_inc);
               src_row_addr_in = src_row_step;
               dst_row_addr_in = dst_row_step;
            end
         end
      end
   end

   always_comb begin
      out_v_in     = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_v_ff);
      out_src_in   = emit ? src_wide[sic_pkg::OUT_WIDTH-1:0]   : out_src_ff;
      out_dst_in   = emit ? dst_wide[sic_pkg::OUT_WIDTH-1:0]   : out_dst_ff;
      out_bytes_in = emit ? bytes_wide[sic_pkg::OUT_WIDTH-1:0] : out_bytes_ff;
      out_last_in  = emit ? fin : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff         <= 1'b0;
         burst_mode_ff     <= sic_pkg::BURST_SLICE;
         row_count_ff      <= '0;
         slice_count_ff    <= '0;
         rows_total_ff     <= '0;
         slices_total_ff   <= '0;
         burst_bytes_ff    <= '0;
         src_slice_addr_ff <= '0;
         dst_slice_addr_ff <= '0;
         src_row_addr_ff   <= '0;
         dst_row_addr_ff   <= '0;
         out_v_ff          <= 1'b0;
      end else begin
         active_ff         <= active_in;
         burst_mode_ff     <= burst_mode_in;
         row_count_ff      <= row_count_in;
         slice_count_ff    <= slice_count_in;
         rows_total_ff     <= rows_total_in;
         slices_total_ff   <= slices_total_in;
         burst_bytes_ff    <= burst_bytes_in;
         src_slice_addr_ff <= src_slice_addr_in;
         dst_slice_addr_ff <= dst_slice_addr_in;
         src_row_addr_ff   <= src_row_addr_in;
         dst_row_addr_ff   <= dst_row_addr_in;
         out_v_ff          <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_src_ff   <= out_src_in;
      out_dst_ff   <= out_dst_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.src_addr   = out_src_ff;
   assign rsp.dst_addr   = out_dst_ff;
   assign rsp.byte_count = out_bytes_ff;
   assign rsp.last       = out_last_ff;

   // final burst closes the copy
   `SIC_ASSERT_NXT(a_last_idles, clock, reset, emit && fin, !active_ff && out_last_ff)
   // a running copy never has empty totals
   `SIC_ASSERT_IMP(a_totals_nonzero, clock, reset, active_ff,
      (rows_total_ff != '0) && (slices_total_ff != '0))
   // counters stay inside the box
   `SIC_ASSERT_IMP(a_counts_in_range, clock, reset, active_ff,
      (row_count_ff < rows_total_ff) && (slice_count_ff < slices_total_ff))
   // merged copy is a single burst
   `SIC_ASSERT_IMP(a_slice_mode_single, clock, reset,
      active_ff && (burst_mode_ff == sic_pkg::BURST_SLICE),
      (rows_total_ff == DIM_WIDTH'(1)) && (slices_total_ff == DIM_WIDTH'(1)))

endmodule

@@ hdl/strided_image_copy_address_gen.sv @@
// path: a request transfer passes the product stage, then the address sum stage,
//    then the walker state and response registers, before its burst shows on rsp
// throughput: one request per cycle while rsp is ready; the walker updates its
//    row and slice state in the same cycle it loads the response register
// reset: synchronous, clears pipeline valids, walker state and configuration to reset values
// top level of the strided image copy address generator
module strided_image_copy_address_gen #(
   parameter int ADDR_WIDTH = sic_pkg::ADDR_WIDTH,
   parameter int DIM_WIDTH  = sic_pkg::DIM_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   sic_req_if.sink                            req,
   sic_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sic_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [sic_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [sic_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                               pready
);

   sic_pkg::sic_cfg_type  cfg;
   sic_pkg::sic_cmd_type  cmd;
   logic [DIM_WIDTH-1:0]  cmd_rows_total;
   logic [DIM_WIDTH-1:0]  cmd_slices_total;
   logic [ADDR_WIDTH-1:0] cmd_bytes;
   logic [ADDR_WIDTH-1:0] cmd_src;
   logic [ADDR_WIDTH-1:0] cmd_dst;
   logic                  advance;

   sic_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sic_setup #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DIM_WIDTH  (DIM_WIDTH)
   ) u_setup (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req              (req),
      .advance          (advance),
      .cmd              (cmd),
      .cmd_rows_total   (cmd_rows_total),
      .cmd_slices_total (cmd_slices_total),
      .cmd_bytes        (cmd_bytes),
      .cmd_src          (cmd_src),
      .cmd_dst          (cmd_dst)
   );

   sic_walker #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .DIM_WIDTH  (DIM_WIDTH)
   ) u_walker (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .cmd_rows_total   (cmd_rows_total),
      .cmd_slices_total (cmd_slices_total),
      .cmd_bytes        (cmd_bytes),
      .cmd_src          (cmd_src),
      .cmd_dst          (cmd_dst),
      .advance          (advance),
      .rsp              (rsp)
   );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the strided image copy address generator, with random stimulus
module tb;

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_NEXT    = 1'b1;
   localparam int   IDLE_PCT     = 29;
   localparam int   HOLD_AFTER   = 300;
   localparam int   HOLD_CYCLES  = 400;
   localparam int   STEADY_FROM  = 500;
   localparam int   STEADY_TO    = 700;
   localparam int   DRAIN_CYCLES = 8;
   localparam int   PHASE_ITEMS  = 230;
   localparam int   RAND_PHASES  = 5;

   typedef struct packed {
      logic                          kind;
      logic [sic_pkg::DIM_WIDTH-1:0] offset_x;
      logic [sic_pkg::DIM_WIDTH-1:0] offset_y;
      logic [sic_pkg::DIM_WIDTH-1:0] offset_z;
      logic [sic_pkg::DIM_WIDTH-1:0] copy_w;
      logic [sic_pkg::DIM_WIDTH-1:0] copy_h;
      logic [sic_pkg::DIM_WIDTH-1:0] copy_d;
      logic [sic_pkg::DIM_WIDTH-1:0] total_w;
      logic [sic_pkg::DIM_WIDTH-1:0] total_h;
   } copy_req_type;

   typedef struct packed {
      logic [sic_pkg::OUT_WIDTH-1:0] src_addr;
      logic [sic_pkg::OUT_WIDTH-1:0] dst_addr;
      logic [sic_pkg::OUT_WIDTH-1:0] byte_count;
      logic                          last;
   } burst_cmd_type;

   typedef struct {
      logic                           active;
      int unsigned                    row_idx;
      int unsigned                    slice_idx;
      int unsigned                    rows_per_slice;
      int unsigned                    slices_per_copy;
      logic [sic_pkg::ADDR_WIDTH-1:0] burst_len;
      logic [sic_pkg::ADDR_WIDTH-1:0] src_slice;
      logic [sic_pkg::ADDR_WIDTH-1:0] dst_slice;
      logic [sic_pkg::ADDR_WIDTH-1:0] src_row;
      logic [sic_pkg::ADDR_WIDTH-1:0] dst_row;
   } copy_walk_type;

   logic                               clock;
   logic                               reset;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [sic_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [sic_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [sic_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                               pready;

   sic_req_if req_ch ();
   sic_rsp_if rsp_ch ();

   strided_image_copy_address_gen i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   copy_req_type         pending_reqs[$];
   burst_cmd_type        expected_bursts[$];
   sic_pkg::sic_cfg_type copy_cfg;
   copy_walk_type        walk;
   copy_req_type         cur_req;
   int unsigned          reqs_queued;
   int unsigned          reqs_sent;
   int unsigned          bursts_seen;
   int unsigned          mismatches;
   int unsigned          hold_left;
   bit                   hold_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic bit steady_window();
      return reqs_sent >= STEADY_FROM && reqs_sent < STEADY_TO;
   endfunction

   // walker: issue the current burst and step to the next row or slice
   function automatic burst_cmd_type next_burst();
      burst_cmd_type cmd;
      cmd.src_addr   = walk.src_row;
      cmd.dst_addr   = walk.dst_row;
      cmd.byte_count = walk.burst_len;
      cmd.last       = (walk.slice_idx + 1 >= walk.slices_per_copy) &&
                       (walk.row_idx + 1 >= walk.rows_per_slice);
      if (cmd.last) begin
         walk.active = 1'b0;
      end else begin
         walk.row_idx = walk.row_idx + 1;
         if (walk.row_idx >= walk.rows_per_slice) begin
            walk.row_idx   = 0;
            walk.slice_idx = walk.slice_idx + 1;
            walk.src_slice = walk.src_slice + copy_cfg.src_slice_pitch;
            walk.dst_slice = walk.dst_slice + copy_cfg.dst_slice_pitch;
            walk.src_row   = walk.src_slice;
            walk.dst_row   = walk.dst_slice;
         end else begin
            walk.src_row = walk.src_row + copy_cfg.src_row_pitch;
            walk.dst_row = walk.dst_row + copy_cfg.dst_row_pitch;
         end
      end
      return cmd;
   endfunction

   function automatic void predict_bursts(copy_req_type r);
      logic [63:0] bpp, bpb, ox, oy, oz, w, h, tw, th, depth;
      logic [63:0] off_x, off_y, src_a, dst_a, prod;
      logic        whole_row, whole_slice;
      if (r.kind == KIND_NEXT) begin
         if (walk.active) expected_bursts.push_back(next_burst());
         return;
      end
      bpp   = 64'(copy_cfg.bits_per_pixel);
      ox    = 64'(r.offset_x);
      oy    = 64'(r.offset_y);
      oz    = 64'(r.offset_z);
      w     = 64'(r.copy_w);
      h     = 64'(r.copy_h);
      tw    = 64'(r.total_w);
      th    = 64'(r.total_h);
      depth = 64'(r.copy_d);
      if (copy_cfg.mode_flags[sic_pkg::MODE_BLOCK]) begin
         bpb   = bpp << sic_pkg::BPB_SHIFT;
         off_x = ((ox >> sic_pkg::BLOCK_SHIFT) * bpp) << sic_pkg::BLOCK_X_SHIFT;
         off_y = oy >> sic_pkg::BLOCK_SHIFT;
         w     = (w + sic_pkg::BLOCK_ROUND) >> sic_pkg::BLOCK_SHIFT;
         h     = (h + sic_pkg::BLOCK_ROUND) >> sic_pkg::BLOCK_SHIFT;
         tw    = (tw + sic_pkg::BLOCK_ROUND) >> sic_pkg::BLOCK_SHIFT;
         th    = (th + sic_pkg::BLOCK_ROUND) >> sic_pkg::BLOCK_SHIFT;
      end else begin
         bpb   = bpp;
         off_x = (ox * bpp) >> sic_pkg::BYTE_SHIFT;
         off_y = oy;
      end
      src_a = 64'(copy_cfg.src_base);
      if (copy_cfg.mode_flags[sic_pkg::MODE_ADJ_SRC])
         src_a = src_a + oz * copy_cfg.src_slice_pitch + off_y * copy_cfg.src_row_pitch + off_x;
      dst_a = 64'(copy_cfg.dst_base);
      if (copy_cfg.mode_flags[sic_pkg::MODE_ADJ_DST])
         dst_a = dst_a + oz * copy_cfg.dst_slice_pitch + off_y * copy_cfg.dst_row_pitch + off_x;
      whole_row   = (w == tw) && (copy_cfg.src_row_pitch == copy_cfg.dst_row_pitch);
      whole_slice = whole_row && copy_cfg.mode_flags[sic_pkg::MODE_3D] && (h == th) &&
                    (copy_cfg.src_slice_pitch == copy_cfg.dst_slice_pitch);
      walk.src_slice = src_a[sic_pkg::ADDR_WIDTH-1:0];
      walk.src_row   = src_a[sic_pkg::ADDR_WIDTH-1:0];
      walk.dst_slice = dst_a[sic_pkg::ADDR_WIDTH-1:0];
      walk.dst_row   = dst_a[sic_pkg::ADDR_WIDTH-1:0];
      walk.row_idx   = 0;
      walk.slice_idx = 0;
      if (whole_slice) begin
         walk.rows_per_slice  = 1;
         walk.slices_per_copy = 1;
         prod = copy_cfg.src_slice_pitch * depth;
      end else if (whole_row) begin
         walk.rows_per_slice  = 1;
         walk.slices_per_copy = depth[31:0];
         prod = copy_cfg.src_row_pitch * h;
      end else begin
         walk.rows_per_slice  = h[31:0];
         walk.slices_per_copy = depth[31:0];
         prod = (bpb * w) >> sic_pkg::BYTE_SHIFT;
      end
      walk.burst_len = prod[sic_pkg::ADDR_WIDTH-1:0];
      if (depth == 0 || walk.rows_per_slice == 0) begin
         walk.active = 1'b0;
      end else begin
         walk.active = 1'b1;
         expected_bursts.push_back(next_burst());
      end
   endfunction

   function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_req(copy_req_type r);
      pending_reqs.push_back(r);
      reqs_queued++;
   endfunction

   function automatic copy_req_type random_req(logic kind);
      copy_req_type r;
      r.kind     = kind;
      r.offset_x = sic_pkg::DIM_WIDTH'($urandom);
      r.offset_y = sic_pkg::DIM_WIDTH'($urandom);
      r.offset_z = sic_pkg::DIM_WIDTH'($urandom);
      r.copy_w   = sic_pkg::DIM_WIDTH'($urandom);
      r.copy_h   = sic_pkg::DIM_WIDTH'($urandom);
      r.copy_d   = sic_pkg::DIM_WIDTH'($urandom);
      r.total_w  = sic_pkg::DIM_WIDTH'($urandom);
      r.total_h  = sic_pkg::DIM_WIDTH'($urandom);
      return r;
   endfunction

   function automatic void queue_start(int unsigned ox, int unsigned oy, int unsigned oz,
                                       int unsigned w, int unsigned h, int unsigned d,
                                       int unsigned tw, int unsigned th);
      copy_req_type r;
      r.kind     = KIND_START;
      r.offset_x = sic_pkg::DIM_WIDTH'(ox);
      r.offset_y = sic_pkg::DIM_WIDTH'(oy);
      r.offset_z = sic_pkg::DIM_WIDTH'(oz);
      r.copy_w   = sic_pkg::DIM_WIDTH'(w);
      r.copy_h   = sic_pkg::DIM_WIDTH'(h);
      r.copy_d   = sic_pkg::DIM_WIDTH'(d);
      r.total_w  = sic_pkg::DIM_WIDTH'(tw);
      r.total_h  = sic_pkg::DIM_WIDTH'(th);
      queue_req(r);
   endfunction

   function automatic void queue_next();
      queue_req(random_req(KIND_NEXT));
   endfunction

   // image size equal to, just above, or unrelated to the box size
   function automatic int unsigned near_size(int unsigned sz, int unsigned span);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return sz;
      if (roll < 7) return sz + $urandom_range(0, 3);
      return $urandom_range(0, span);
   endfunction

   task automatic queue_random_phase(int unsigned target);
      int unsigned  n, roll, steps, w, h;
      copy_req_type r;
      n = 0;
      while (n < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            queue_req(random_req(1'($urandom_range(0, 1))));
            n++;
         end else begin
            r = random_req(KIND_START);
            if (roll >= 18) begin
               w         = $urandom_range(0, 40);
               h         = $urandom_range(0, 6);
               r.copy_w  = sic_pkg::DIM_WIDTH'(w);
               r.copy_h  = sic_pkg::DIM_WIDTH'(h);
               r.copy_d  = sic_pkg::DIM_WIDTH'($urandom_range(0, 4));
               r.total_w = sic_pkg::DIM_WIDTH'(near_size(w, 40));
               r.total_h = sic_pkg::DIM_WIDTH'(near_size(h, 8));
               steps     = h * r.copy_d + 1;
               if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, steps);
            end else begin
               steps = $urandom_range(0, 6);
            end
            queue_req(r);
            n++;
            repeat (steps) begin
               queue_next();
               n++;
            end
         end
      end
      // leave the walker idle before the next register change
      queue_start($urandom, $urandom, $urandom, $urandom, $urandom, 0, $urandom, $urandom);
   endtask

   task automatic write_csr(sic_pkg::sic_reg_type idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= sic_pkg::CSR_ADDR_WIDTH'(idx) << sic_pkg::REG_INDEX_LSB;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         sic_pkg::REG_MODE_FLAGS:
            copy_cfg.mode_flags      = value[sic_pkg::MODE_WIDTH-1:0];
         sic_pkg::REG_BITS_PER_PIXEL:
            copy_cfg.bits_per_pixel  = value[sic_pkg::BPP_WIDTH-1:0];
         sic_pkg::REG_SRC_BASE:
            copy_cfg.src_base        = value[sic_pkg::BASE_WIDTH-1:0];
         sic_pkg::REG_DST_BASE:
            copy_cfg.dst_base        = value[sic_pkg::BASE_WIDTH-1:0];
         sic_pkg::REG_SRC_ROW_PITCH:
            copy_cfg.src_row_pitch   = value[sic_pkg::ROW_PITCH_WIDTH-1:0];
         sic_pkg::REG_DST_ROW_PITCH:
            copy_cfg.dst_row_pitch   = value[sic_pkg::ROW_PITCH_WIDTH-1:0];
         sic_pkg::REG_SRC_SLICE_PITCH:
            copy_cfg.src_slice_pitch = value[sic_pkg::SLICE_PITCH_WIDTH-1:0];
         sic_pkg::REG_DST_SLICE_PITCH:
            copy_cfg.dst_slice_pitch = value[sic_pkg::SLICE_PITCH_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic program_setting(logic [3:0] mode, logic [7:0] bpp,
                                  logic [31:0] sbase, logic [31:0] dbase,
                                  logic [23:0] srp, logic [23:0] drp,
                                  logic [31:0] ssp, logic [31:0] dsp);
      write_csr(sic_pkg::REG_MODE_FLAGS, 32'(mode));
      write_csr(sic_pkg::REG_BITS_PER_PIXEL, 32'(bpp));
      write_csr(sic_pkg::REG_SRC_BASE, sbase);
      write_csr(sic_pkg::REG_DST_BASE, dbase);
      write_csr(sic_pkg::REG_SRC_ROW_PITCH, 32'(srp));
      write_csr(sic_pkg::REG_DST_ROW_PITCH, 32'(drp));
      write_csr(sic_pkg::REG_SRC_SLICE_PITCH, ssp);
      write_csr(sic_pkg::REG_DST_SLICE_PITCH, dsp);
   endtask

   task automatic program_random_setting();
      logic [23:0] srp, drp;
      logic [31:0] ssp, dsp;
      logic [7:0]  bpp;
      if ($urandom_range(0, 3) == 0) srp = 24'($urandom);
      else srp = 24'($urandom_range(0, 4096));
      if ($urandom_range(0, 1) == 0) drp = srp;
      else if ($urandom_range(0, 3) == 0) drp = 24'($urandom);
      else drp = 24'($urandom_range(0, 4096));
      if ($urandom_range(0, 2) == 0) ssp = $urandom;
      else ssp = $urandom_range(0, 65536);
      if ($urandom_range(0, 1) == 0) dsp = ssp;
      else dsp = $urandom;
      if ($urandom_range(0, 4) == 0) bpp = 8'($urandom);
      else bpp = 8'($urandom_range(1, 128));
      program_setting(4'($urandom), bpp, $urandom, $urandom, srp, drp, ssp, dsp);
   endtask

   task automatic wait_drained();
      while (reqs_sent != reqs_queued || expected_bursts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_bursts(cur_req);
            reqs_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 &&
                (steady_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               cur_req          = pending_reqs.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.kind     <= cur_req.kind;
               req_ch.offset_x <= cur_req.offset_x;
               req_ch.offset_y <= cur_req.offset_y;
               req_ch.offset_z <= cur_req.offset_z;
               req_ch.copy_w   <= cur_req.copy_w;
               req_ch.copy_h   <= cur_req.copy_h;
               req_ch.copy_d   <= cur_req.copy_d;
               req_ch.total_w  <= cur_req.total_w;
               req_ch.total_h  <= cur_req.total_h;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!hold_done && bursts_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (steady_window()) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_bursts
      burst_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         bursts_seen++;
         if (expected_bursts.size() == 0) begin
            $display("%0t: unexpected burst transfer, expected none, actual %h %h %h %b",
                     $time, rsp_ch.src_addr, rsp_ch.dst_addr, rsp_ch.byte_count, rsp_ch.last);
            mismatches++;
         end else begin
            want = expected_bursts.pop_front();
            check_field("src_addr", want.src_addr, rsp_ch.src_addr);
            check_field("dst_addr", want.dst_addr, rsp_ch.dst_addr);
            check_field("byte_count", want.byte_count, rsp_ch.byte_count);
            check_field("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_ch.valid    = 1'b0;
      req_ch.kind     = KIND_NEXT;
      req_ch.offset_x = '0;
      req_ch.offset_y = '0;
      req_ch.offset_z = '0;
      req_ch.copy_w   = '0;
      req_ch.copy_h   = '0;
      req_ch.copy_d   = '0;
      req_ch.total_w  = '0;
      req_ch.total_h  = '0;
      rsp_ch.ready    = 1'b0;
      copy_cfg        = '0;
      copy_cfg.bits_per_pixel = sic_pkg::BPP_RESET;
      walk.active     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values: next while idle, then a short per row copy
      queue_next();
      queue_start(3, 0, 0, 4, 2, 2, 8, 9);
      repeat (4) queue_next();
      wait_drained();

      // adjusted addresses, destination wrapping, empty copies, abandoned copy
      program_setting(4'b0110, 8'd24, 32'h0000_1000, 32'hFFFF_FF00,
                      24'h00_0100, 24'h00_0200, 32'h0001_0000, 32'h0002_0000);
      queue_start(5, 2, 1, 10, 2, 2, 100, 50);
      repeat (3) queue_next();
      queue_start(1, 1, 1, 4, 4, 0, 8, 8);
      queue_next();
      queue_start(1, 1, 1, 4, 0, 3, 8, 8);
      queue_start(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383);
      queue_next();
      queue_start(9, 9, 9, 1, 1, 1, 2, 2);
      wait_drained();

      // upper extremes: whole slice, whole row with zero height, long per row copy
      program_setting(4'hF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_start(16383, 16383, 16383, 5, 5, 16383, 8, 8);
      queue_start(0, 0, 0, 16383, 0, 3, 16383, 4);
      repeat (2) queue_next();
      queue_start(1, 2, 3, 1, 16383, 16383, 8, 16383);
      queue_next();
      queue_start(0, 0, 0, 1, 1, 0, 1, 1);
      wait_drained();

      // lower extremes: zero pitches and zero bits per pixel
      program_setting(4'b1000, 8'd0, 32'd0, 32'd0, 24'd0, 24'd0, 32'd0, 32'd0);
      queue_start(7, 7, 7, 7, 3, 2, 7, 3);
      queue_start(1, 1, 1, 3, 1, 1, 4, 1);
      wait_drained();

      repeat (RAND_PHASES) begin
         program_random_setting();
         queue_random_phase(PHASE_ITEMS);
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
